[sv/dcpu_pkg.sv]
// ----------------------------------------------------------------------------
// dcpu_pkg
// Shared widths, payload types and helpers for the distance constraint
// projection unit.
// ----------------------------------------------------------------------------
package dcpu_pkg;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 32;
  localparam int REST_W  = 31;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MAG_W   = POS_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int NUM_W   = MAG_W + REST_W;
  localparam int QUO_W   = REST_W;
  localparam int DREM_W  = ROOT_W;
  localparam int CORR_W  = DIFF_W + 1;
  localparam int WIDE_W  = CORR_W + 1;
  localparam int LANES   = 3;

  typedef struct packed {
    logic [IDX_W-1:0]              idx0;
    logic [IDX_W-1:0]              idx1;
    logic [LANES-1:0][POS_W-1:0]   p0;
    logic [LANES-1:0][POS_W-1:0]   p1;
    logic                          mov0;
    logic                          mov1;
    logic [REST_W-1:0]             rest;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_t;

  typedef struct packed {
    item_t                       it;
    logic                        degen;
    logic [LANES-1:0][NUM_W-1:0] num;
  } carry_t;

  typedef struct packed {
    item_t                        it;
    logic                         degen;
    logic [ROOT_W-1:0]            len;
    logic [LANES-1:0][DREM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0]  nbits;
    logic [LANES-1:0][QUO_W-1:0]  quo;
  } div_t;

  // p1 - p0, exact
  function automatic logic [DIFF_W-1:0] pos_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    pos_diff = {b[POS_W-1], b} - {a[POS_W-1], a};
  endfunction

  // clamp to the signed position range
  function automatic logic [POS_W-1:0] sat_pos(input logic [WIDE_W-1:0] v);
    logic hi_ok;
    hi_ok = (v[WIDE_W-1:POS_W-1] == '0) || (v[WIDE_W-1:POS_W-1] == '1);
    if (hi_ok) sat_pos = v[POS_W-1:0];
    else if (v[WIDE_W-1]) sat_pos = {1'b1, {(POS_W-1){1'b0}}};
    else sat_pos = {1'b0, {(POS_W-1){1'b1}}};
  endfunction

endpackage

[sv/dcpu_in_if.sv]
// ----------------------------------------------------------------------------
// dcpu_in_if
// Constraint input channel: valid/ready plus one constraint.
// ----------------------------------------------------------------------------
interface dcpu_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  first_index;
  logic [9:0]  second_index;
  logic [31:0] first_x;
  logic [31:0] first_y;
  logic [31:0] first_z;
  logic [31:0] second_x;
  logic [31:0] second_y;
  logic [31:0] second_z;
  logic        first_movable;
  logic        second_movable;
  logic [30:0] rest_length;

  modport source (output valid, first_index, second_index, first_x, first_y, first_z,
                  second_x, second_y, second_z, first_movable, second_movable,
                  rest_length, input ready);
  modport sink (input valid, first_index, second_index, first_x, first_y, first_z,
                second_x, second_y, second_z, first_movable, second_movable,
                rest_length, output ready);
endinterface

[sv/dcpu_out_if.sv]
// ----------------------------------------------------------------------------
// dcpu_out_if
// Result channel: valid/ready plus corrected positions.
// ----------------------------------------------------------------------------
interface dcpu_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_first_index;
  logic [9:0]  out_second_index;
  logic [31:0] new_first_x;
  logic [31:0] new_first_y;
  logic [31:0] new_first_z;
  logic [31:0] new_second_x;
  logic [31:0] new_second_y;
  logic [31:0] new_second_z;
  logic        degenerate;

  modport source (output valid, out_first_index, out_second_index, new_first_x,
                  new_first_y, new_first_z, new_second_x, new_second_y, new_second_z,
                  degenerate, input ready);
  modport sink (input valid, out_first_index, out_second_index, new_first_x,
                new_first_y, new_first_z, new_second_x, new_second_y, new_second_z,
                degenerate, output ready);
endinterface

[sv/distance_constraint_projection_unit.sv]
// ----------------------------------------------------------------------------
// distance_constraint_projection_unit
// Rest-length constraint relaxation for two particles, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one constraint per transaction: two positions, movable
//   flags, rest length and the two particle indices. out_ch returns one
//   transaction per constraint, in order, with corrected and saturated
//   positions, the indices echoed and a degenerate flag for coincident points.
//   The path is three front stages (capture, squares and scaled
//   magnitudes, sum of squares), 33 square-root cells, one root bit each,
//   31 division cells, one quotient bit each, and the output register.
//   Throughput is one transaction per cycle while the receiver keeps up; the
//   cell chains set the latency, nothing in the path iterates.
//   The whole chain advances together whenever the output register is empty
//   or being taken; when the receiver stalls with a result waiting, the chain
//   holds and in_ch.ready drops, so nothing is lost or repeated.
//   Reset (rst_n low at a clock edge) clears every valid bit; payload
//   registers are left as they are. No configuration.
// ----------------------------------------------------------------------------
module distance_constraint_projection_unit (
  input  logic       clk,
  input  logic       rst_n,
  dcpu_in_if.sink    in_ch,
  dcpu_out_if.source out_ch
);
  import dcpu_pkg::*;

  localparam int NSQ  = ROOT_W;
  localparam int NDIV = QUO_W;

  logic   adv;
  item_t  in_item;

  logic             fr_valid;
  logic [SUM_W-1:0] fr_sum;
  carry_t           fr_carry;

  logic   sq_v [0:NSQ];
  sqrt_t  sq_d [0:NSQ];
  carry_t sq_c [0:NSQ];

  logic dv_v [0:NDIV];
  div_t dv_d [0:NDIV];

  // output register
  logic                        out_valid_r;
  logic [IDX_W-1:0]            idx0_r, idx1_r;
  logic [LANES-1:0][POS_W-1:0] np0_r, np1_r, np0_nxt, np1_nxt;
  logic                        degen_r;

  // advance the whole chain unless a finished result is stuck
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    in_item.idx0  = in_ch.first_index;
    in_item.idx1  = in_ch.second_index;
    in_item.p0[0] = in_ch.first_x;
    in_item.p0[1] = in_ch.first_y;
    in_item.p0[2] = in_ch.first_z;
    in_item.p1[0] = in_ch.second_x;
    in_item.p1[1] = in_ch.second_y;
    in_item.p1[2] = in_ch.second_z;
    in_item.mov0  = in_ch.first_movable;
    in_item.mov1  = in_ch.second_movable;
    in_item.rest  = in_ch.rest_length;
  end

  dcpu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .out_valid(fr_valid),
    .out_sum  (fr_sum),
    .out_carry(fr_carry)
  );

  // seed the root chain: all radicand bits pending, root and remainder zero
  assign sq_v[0]      = fr_valid;
  assign sq_d[0].rad  = fr_sum;
  assign sq_d[0].root = '0;
  assign sq_d[0].rem  = '0;
  assign sq_c[0]      = fr_carry;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    dcpu_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (sq_v[g]),
      .in_sq    (sq_d[g]),
      .in_carry (sq_c[g]),
      .out_valid(sq_v[g+1]),
      .out_sq   (sq_d[g+1]),
      .out_carry(sq_c[g+1])
    );
  end

  // seed the divider: the quotient fits the rest length width, so the
  // upper numerator bits already sit below the length
  always_comb begin
    dv_v[0]       = sq_v[NSQ];
    dv_d[0].it    = sq_c[NSQ].it;
    dv_d[0].degen = sq_c[NSQ].degen;
    dv_d[0].len   = sq_d[NSQ].root;
    for (int i = 0; i < LANES; i++) begin
      dv_d[0].rem[i]   = DREM_W'(sq_c[NSQ].num[i][NUM_W-1:QUO_W]);
      dv_d[0].nbits[i] = sq_c[NSQ].num[i][QUO_W-1:0];
      dv_d[0].quo[i]   = '0;
    end
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    dcpu_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv_v[g]),
      .in_dv    (dv_d[g]),
      .out_valid(dv_v[g+1]),
      .out_dv   (dv_d[g+1])
    );
  end

  // apply the correction: full step for a lone movable particle, half each
  // when both move, nothing when neither moves or the points coincide
  always_comb begin
    item_t it;
    logic  hold;
    it   = dv_d[NDIV].it;
    hold = dv_d[NDIV].degen || !(it.mov0 || it.mov1);
    for (int i = 0; i < LANES; i++) begin
      logic [DIFF_W-1:0] d;
      logic [CORR_W-1:0] qs, c, h, corr;
      logic [WIDE_W-1:0] a0, a1;
      d  = pos_diff(it.p0[i], it.p1[i]);
      qs = d[DIFF_W-1] ? CORR_W'(-{3'b000, dv_d[NDIV].quo[i]})
                       : CORR_W'({3'b000, dv_d[NDIV].quo[i]});
      c  = {d[DIFF_W-1], d} - qs;
      h  = $signed(c + CORR_W'(c[CORR_W-1])) >>> 1;
      corr = (it.mov0 && it.mov1) ? h : c;
      a0 = {{3{it.p0[i][POS_W-1]}}, it.p0[i]};
      a1 = {{3{it.p1[i][POS_W-1]}}, it.p1[i]};
      if (!hold && it.mov0) a0 = a0 + {corr[CORR_W-1], corr};
      if (!hold && it.mov1) a1 = a1 - {corr[CORR_W-1], corr};
      np0_nxt[i] = sat_pos(a0);
      np1_nxt[i] = sat_pos(a1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v[NDIV];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx0_r  <= dv_d[NDIV].it.idx0;
      idx1_r  <= dv_d[NDIV].it.idx1;
      np0_r   <= np0_nxt;
      np1_r   <= np1_nxt;
      degen_r <= dv_d[NDIV].degen;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_first_index  = idx0_r;
  assign out_ch.out_second_index = idx1_r;
  assign out_ch.new_first_x      = np0_r[0];
  assign out_ch.new_first_y      = np0_r[1];
  assign out_ch.new_first_z      = np0_r[2];
  assign out_ch.new_second_x     = np1_r[0];
  assign out_ch.new_second_y     = np1_r[1];
  assign out_ch.new_second_z     = np1_r[2];
  assign out_ch.degenerate       = degen_r;

  // coincident points pass unchanged, so both outputs must agree
  a_degen_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && degen_r) |-> (np0_r == np1_r))
    else $error("degenerate result with differing positions");

endmodule

[sv/dcpu_front.sv]
// ----------------------------------------------------------------------------
// dcpu_front
// Three-stage head: capture, square and scale, sum of squares.
// ----------------------------------------------------------------------------
module dcpu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  dcpu_pkg::item_t       in_item,
  output logic                  out_valid,
  output logic [dcpu_pkg::SUM_W-1:0] out_sum,
  output dcpu_pkg::carry_t      out_carry
);
  import dcpu_pkg::*;

  logic                        v1_r, v2_r, v3_r;
  item_t                       it1_r, it2_r;
  logic [LANES-1:0][SQ_W-1:0]  sq2_r;
  logic [LANES-1:0][NUM_W-1:0] num2_r;
  logic [SUM_W-1:0]            sum3_r;
  carry_t                      c3_r;

  logic [LANES-1:0][MAG_W-1:0] mag;
  logic [SUM_W-1:0]            sum_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [DIFF_W-1:0] d;
      d = pos_diff(it1_r.p0[i], it1_r.p1[i]);
      mag[i] = d[DIFF_W-1] ? MAG_W'(-d) : d[MAG_W-1:0];
    end
    sum_nxt = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      it2_r <= it1_r;
      for (int i = 0; i < LANES; i++) begin
        sq2_r[i]  <= mag[i] * mag[i];
        num2_r[i] <= mag[i] * it1_r.rest;
      end
      sum3_r   <= sum_nxt;
      c3_r.it  <= it2_r;
      c3_r.degen <= (sum_nxt == '0);
      c3_r.num <= num2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_sum   = sum3_r;
  assign out_carry = c3_r;

endmodule

[sv/dcpu_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// dcpu_sqrt_cell
// One root bit of the integer square root: shift in a bit pair, trial subtract.
// ----------------------------------------------------------------------------
module dcpu_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  dcpu_pkg::sqrt_t   in_sq,
  input  dcpu_pkg::carry_t  in_carry,
  output logic              out_valid,
  output dcpu_pkg::sqrt_t   out_sq,
  output dcpu_pkg::carry_t  out_carry
);
  import dcpu_pkg::*;

  logic             valid_r;
  sqrt_t            sq_r, sq_nxt;
  carry_t           carry_r;
  logic [REM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {in_sq.rem[REM_W-3:0], in_sq.rad[SUM_W-1:SUM_W-2]};
    trial  = {in_sq.root, 2'b01};
    sq_nxt.rad = {in_sq.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = rem_sh - trial;
      sq_nxt.root = {in_sq.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh;
      sq_nxt.root = {in_sq.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (en) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sq_nxt;
      carry_r <= in_carry;
    end
  end

  assign out_valid = valid_r;
  assign out_sq    = sq_r;
  assign out_carry = carry_r;

  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (sq_r.rem <= {1'b0, sq_r.root, 1'b0}))
    else $error("sqrt remainder out of bound");

endmodule

[sv/dcpu_div_cell.sv]
// ----------------------------------------------------------------------------
// dcpu_div_cell
// One quotient bit of restoring division, three lanes against a shared length.
// ----------------------------------------------------------------------------
module dcpu_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  dcpu_pkg::div_t  in_dv,
  output logic            out_valid,
  output dcpu_pkg::div_t  out_dv
);
  import dcpu_pkg::*;

  logic valid_r;
  div_t dv_r, dv_nxt;

  always_comb begin
    dv_nxt = in_dv;
    for (int i = 0; i < LANES; i++) begin
      logic [DREM_W:0] rn;
      logic            ge;
      rn = {in_dv.rem[i], in_dv.nbits[i][QUO_W-1]};
      ge = (rn >= {1'b0, in_dv.len});
      dv_nxt.rem[i]   = ge ? DREM_W'(rn - {1'b0, in_dv.len}) : rn[DREM_W-1:0];
      dv_nxt.nbits[i] = {in_dv.nbits[i][QUO_W-2:0], 1'b0};
      dv_nxt.quo[i]   = {in_dv.quo[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (en) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) dv_r <= dv_nxt;
  end

  assign out_valid = valid_r;
  assign out_dv    = dv_r;

  // partial remainder stays below the divisor for a real constraint
  a_rem_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !dv_r.degen) |->
      ((dv_r.rem[0] < dv_r.len) && (dv_r.rem[1] < dv_r.len) && (dv_r.rem[2] < dv_r.len)))
    else $error("division remainder not below length");

endmodule
